// ===== design/mhic_pkg.sv =====
// ----------------------------------------------------------------------------
// mhic_pkg
// shared field and word widths, reset values and types for the hard-iron calibration
// ----------------------------------------------------------------------------
package mhic_pkg;

  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned SUM_W     = 17;
  localparam int unsigned DIFF_W    = 18;
  localparam int unsigned SCALE_W   = 32;
  localparam int unsigned FIELD_W   = 50;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 208;

  localparam logic [SAMPLE_W-1:0] PEAK_RESET   = 16'h8000;
  localparam logic [SAMPLE_W-1:0] TROUGH_RESET = 16'h7fff;
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 32'd284853140;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic signed [FIELD_W-1:0]  field_t;

endpackage

// ===== design/mhic_track.sv =====
// ----------------------------------------------------------------------------
// mhic_track
// running peak and trough of one axis, registered offset sum and centered
// sample
// ----------------------------------------------------------------------------
module mhic_track import mhic_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    upd_en,
  input  sample_t raw,
  output sum_t    sum_r,
  output diff_t   diff_r
);

  sample_t peak_r, peak_nxt;
  sample_t trough_r, trough_nxt;
  sum_t    sum_nxt;
  diff_t   diff_nxt;

  always_comb begin
    peak_nxt   = (raw > peak_r) ? raw : peak_r;
    trough_nxt = (raw < trough_r) ? raw : trough_r;
    sum_nxt    = SUM_W'(peak_nxt) + SUM_W'(trough_nxt);
    diff_nxt   = $signed({raw[SAMPLE_W-1], raw, 1'b0}) - DIFF_W'(sum_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r   <= PEAK_RESET;
      trough_r <= TROUGH_RESET;
    end else if (upd_en) begin
      peak_r   <= peak_nxt;
      trough_r <= trough_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      sum_r  <= sum_nxt;
      diff_r <= diff_nxt;
    end
  end

`ifndef SYNTHESIS
  a_peak_rises: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> peak_r >= $past(peak_r))
    else $error("peak decreased");

  a_trough_falls: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> trough_r <= $past(trough_r))
    else $error("trough increased");

  a_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    upd_en |=> peak_r >= trough_r)
    else $error("peak below trough after update");
`endif

endmodule

// ===== design/mhic_scale.sv =====
// ----------------------------------------------------------------------------
// mhic_scale
// registered product of the centered sample and the unsigned q0.32 scale
// ----------------------------------------------------------------------------
module mhic_scale import mhic_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  diff_t              diff,
  input  logic [SCALE_W-1:0] scale,
  output field_t             field_r
);

  logic signed [SCALE_W:0]   scale_s;
  logic signed [FIELD_W:0]   prod;

  assign scale_s = $signed({1'b0, scale});
  assign prod    = diff * scale_s;

  always_ff @(posedge clk) begin
    if (en) begin
      field_r <= prod[FIELD_W-1:0];
    end
  end

endmodule

// ===== design/magnetometer_hard_iron_calibration_core.sv =====
// ----------------------------------------------------------------------------
// magnetometer_hard_iron_calibration_core
// min/max hard-iron calibration of a three-axis magnetometer frame
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// in_      in   in_tvalid/in_tready  in_tdata   48 bits, x z y byte pairs
// out_     out  out_tvalid/out_tready out_tdata 208 bits, fields and offsets
// cfg_     in   cfg_valid/cfg_ready  cfg_data   32 bits, field_scale
//
// one word per cycle while out_tready does not stall the pipeline; an accepted
// word passes the input register, the extremes and centering stage and the
// multiply into the output register before it is offered on out_
// rst_n clears the extremes, valid flags and restores the default scale
// out_tready low holds the pipeline; stages fill while the output waits
// cfg_ready is always high
// ----------------------------------------------------------------------------
module magnetometer_hard_iron_calibration_core import mhic_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // x_high, x_low, z_high, z_low, y_high, y_low
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // field_x, field_y, field_z, offset_sum_x, offset_sum_y, offset_sum_z, pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [SCALE_W-1:0]    cfg_data
);

  logic [SCALE_W-1:0]   scale_r;
  logic                 s1_valid_r, s2_valid_r, out_valid_r;
  logic [IN_DATA_W-1:0] s1_data_r;
  logic                 out_ready, s2_ready, s1_ready;
  logic                 s1_adv, s2_adv;
  sample_t              raw_x, raw_y, raw_z;
  sum_t                 sum_x, sum_y, sum_z;
  diff_t                diff_x, diff_y, diff_z;
  field_t               field_x, field_y, field_z;
  sum_t                 off_x_r, off_y_r, off_z_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_valid) begin
      scale_r <= cfg_data;
    end
  end

  assign out_ready = !out_valid_r || out_tready;
  assign s2_ready  = !s2_valid_r || out_ready;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign s1_adv    = s1_valid_r && s2_ready;
  assign s2_adv    = s2_valid_r && out_ready;
  assign in_tready = s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= in_tvalid;
      if (s2_ready) s2_valid_r <= s1_valid_r;
      if (out_ready) out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && s1_ready) begin
      s1_data_r <= in_tdata;
    end
  end

  assign raw_x = $signed({s1_data_r[7:0],   s1_data_r[15:8]});
  assign raw_z = $signed({s1_data_r[23:16], s1_data_r[31:24]});
  assign raw_y = $signed({s1_data_r[39:32], s1_data_r[47:40]});

  mhic_track u_track_x (.clk, .rst_n, .upd_en(s1_adv), .raw(raw_x),
                        .sum_r(sum_x), .diff_r(diff_x));
  mhic_track u_track_y (.clk, .rst_n, .upd_en(s1_adv), .raw(raw_y),
                        .sum_r(sum_y), .diff_r(diff_y));
  mhic_track u_track_z (.clk, .rst_n, .upd_en(s1_adv), .raw(raw_z),
                        .sum_r(sum_z), .diff_r(diff_z));

  mhic_scale u_scale_x (.clk, .en(s2_adv), .diff(diff_x), .scale(scale_r),
                        .field_r(field_x));
  mhic_scale u_scale_y (.clk, .en(s2_adv), .diff(diff_y), .scale(scale_r),
                        .field_r(field_y));
  mhic_scale u_scale_z (.clk, .en(s2_adv), .diff(diff_z), .scale(scale_r),
                        .field_r(field_z));

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      off_x_r <= sum_x;
      off_y_r <= sum_y;
      off_z_r <= sum_z;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, off_z_r, off_y_r, off_x_r, field_z, field_y, field_x};

`ifndef SYNTHESIS
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_valid_r)
    else $error("accepted word not in input register");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_ready) |=> s1_valid_r && $stable(s1_data_r))
    else $error("input register changed while stalled");

  a_s2_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_valid_r && !out_ready) |=> s2_valid_r && $stable(diff_x) && $stable(sum_z))
    else $error("centering stage changed while stalled");
`endif

endmodule
